FILE: rtl/tldm_pkg.sv
// Shared types and constants for the temperature limit and delta monitor.
// Used by tldm_eval and temperature_limit_delta_monitor_core; no dependencies.
`default_nettype none

package tldm_pkg;

   localparam int NUM_CH     = 4;
   localparam int CH_W       = 2;
   localparam int TEMP_W     = 15;
   localparam int SAMPLE_W   = 16;
   localparam int ARITH_W    = 18;
   localparam int CODE_W     = 7;
   localparam int CODES_W    = 28;
   localparam int CSR_W      = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 8;

   localparam int THRESH_BASE = -5500;
   localparam int THRESH_STEP = 180;

   localparam logic [7:0] MASK_RISE_T2 = 8'h0C;
   localparam logic [7:0] MASK_RISE_T1 = 8'hC0;
   localparam logic [7:0] MASK_FALL_T1 = 8'h30;
   localparam logic [7:0] MASK_FALL_T2 = 8'h03;
   localparam logic [7:0] MASK_DCODE   = 8'h7F;
   localparam logic [7:0] MASK_DEN     = 8'h80;

   localparam logic [CSR_IDX_W-1:0] REG_REACTION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TH1      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TH2      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DELTA    = 2'd3;

   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_SENT   = 1'b1;

   typedef struct packed {
      logic                     func;
      logic [CH_W-1:0]          channel;
      logic signed [TEMP_W-1:0] temperature;
      logic                     restart_pending;
   } item_type;

   typedef struct packed {
      logic [31:0]        reaction_bits;
      logic [CODES_W-1:0] first_codes;
      logic [CODES_W-1:0] second_codes;
      logic [31:0]        delta_settings;
   } cfg_type;

   typedef struct packed {
      logic [CH_W-1:0] out_channel;
      logic            limit_state;
      logic            send_limit;
      logic            start_delta_delay;
   } result_type;

   typedef struct packed {
      logic                       sample_we;
      logic                       sent_we;
      logic                       limit_new;
      logic signed [SAMPLE_W-1:0] sample_new;
   } update_type;

endpackage

`default_nettype wire

FILE: rtl/tldm_eval.sv
// Per-item evaluation: threshold crossing checks, limit bit and delta test.
// Depends on tldm_pkg.
`default_nettype none

module tldm_eval (
   input  var tldm_pkg::item_type                     item,
   input  var tldm_pkg::cfg_type                      cfg,
   input  var logic signed [tldm_pkg::SAMPLE_W-1:0]   prev_sample,
   input  var logic signed [tldm_pkg::SAMPLE_W-1:0]   last_sent,
   input  var logic                                   limit_old,
   output tldm_pkg::result_type                       result,
   output tldm_pkg::update_type                       update
);

   logic [7:0]                           react;
   logic [7:0]                           dset;
   logic [tldm_pkg::CODE_W-1:0]          code1;
   logic [tldm_pkg::CODE_W-1:0]          code2;
   logic signed [tldm_pkg::ARITH_W-1:0]  th1;
   logic signed [tldm_pkg::ARITH_W-1:0]  th2;
   logic signed [tldm_pkg::ARITH_W-1:0]  t_ext;
   logic signed [tldm_pkg::ARITH_W-1:0]  p_ext;
   logic signed [tldm_pkg::ARITH_W-1:0]  ls_ext;
   logic signed [tldm_pkg::ARITH_W-1:0]  diff;
   logic signed [tldm_pkg::ARITH_W-1:0]  dlimit;
   logic                                 rise2, rise1, fall1, fall2;
   logic                                 crossed;
   logic                                 lim;
   logic                                 is_sample;

   assign react = cfg.reaction_bits[8*item.channel +: 8];
   assign dset  = cfg.delta_settings[8*item.channel +: 8];
   assign code1 = cfg.first_codes[tldm_pkg::CODE_W*item.channel +: tldm_pkg::CODE_W];
   assign code2 = cfg.second_codes[tldm_pkg::CODE_W*item.channel +: tldm_pkg::CODE_W];

   assign th1 = tldm_pkg::ARITH_W'(tldm_pkg::THRESH_BASE)
              + tldm_pkg::ARITH_W'(code1 * tldm_pkg::THRESH_STEP);
   assign th2 = tldm_pkg::ARITH_W'(tldm_pkg::THRESH_BASE)
              + tldm_pkg::ARITH_W'(code2 * tldm_pkg::THRESH_STEP);

   assign t_ext  = tldm_pkg::ARITH_W'(item.temperature);
   assign p_ext  = tldm_pkg::ARITH_W'(prev_sample);
   assign ls_ext = tldm_pkg::ARITH_W'(last_sent);

   assign rise2 = ((p_ext < th2) || item.restart_pending) && (t_ext > th2)
                  && ((react & tldm_pkg::MASK_RISE_T2) != 8'd0);
   assign rise1 = ((p_ext < th1) || item.restart_pending) && (t_ext > th1)
                  && ((react & tldm_pkg::MASK_RISE_T1) != 8'd0);
   assign fall1 = ((p_ext > th1) || item.restart_pending) && (t_ext < th1)
                  && ((react & tldm_pkg::MASK_FALL_T1) != 8'd0);
   assign fall2 = ((p_ext > th2) || item.restart_pending) && (t_ext < th2)
                  && ((react & tldm_pkg::MASK_FALL_T2) != 8'd0);

   assign crossed = rise2 | rise1 | fall1 | fall2;

   // last enabled crossing in check order wins
   always_comb begin
      if (fall2) begin
         lim = react[0];
      end else if (fall1) begin
         lim = react[4];
      end else if (rise1) begin
         lim = react[6];
      end else if (rise2) begin
         lim = react[2];
      end else begin
         lim = limit_old;
      end
   end

   assign diff   = (t_ext <= ls_ext) ? (ls_ext - t_ext) : (t_ext - ls_ext);
   assign dlimit = tldm_pkg::ARITH_W'((dset & tldm_pkg::MASK_DCODE) * tldm_pkg::THRESH_STEP);

   assign is_sample = (item.func == tldm_pkg::FUNC_SAMPLE);

   assign update.sample_we  = is_sample;
   assign update.sent_we    = (item.func == tldm_pkg::FUNC_SENT);
   assign update.limit_new  = is_sample ? lim : limit_old;
   assign update.sample_new = tldm_pkg::SAMPLE_W'(item.temperature);

   assign result.out_channel       = item.channel;
   assign result.limit_state       = update.limit_new;
   assign result.send_limit        = is_sample && crossed && !item.restart_pending;
   assign result.start_delta_delay = is_sample && ((dset & tldm_pkg::MASK_DEN) != 8'd0)
                                     && (diff > dlimit);

endmodule

`default_nettype wire

FILE: rtl/temperature_limit_delta_monitor_core.sv
// Top level: configuration registers, input register, channel state, result register.
// Depends on tldm_pkg and tldm_eval.
`default_nettype none

// Four-channel temperature limit and send-on-delta monitor. Each request beat
// carries either a new sample (tuser = 0) or a sent report (tuser = 1) for one
// channel and yields exactly one response beat. The block takes one beat per
// clock cycle unless rsp_tready back-pressure stalls it. A beat goes from the
// input register through tldm_eval into the response register, which also holds
// a finished beat while the next one is accepted. Channel state is updated as a
// beat enters the response register, so back-to-back beats on one channel see
// each other's results. Write the csr registers only while the block is idle.
module temperature_limit_delta_monitor_core (
   input  var logic                                  clock,
   input  var logic                                  reset,
   input  var logic                                  req_tvalid,
   output logic                                      req_tready,
   // channel[1:0], temperature[16:2], restart_pending[17], zero[23:18]
   input  var logic [tldm_pkg::REQ_DATA_W-1:0]       req_tdata,
   // func[0]
   input  var logic                                  req_tuser,
   output logic                                      rsp_tvalid,
   input  var logic                                  rsp_tready,
   // out_channel[1:0], limit_state[2], send_limit[3], start_delta_delay[4], zero[7:5]
   output logic [tldm_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   input  var logic                                  csr_we,
   input  var logic [tldm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  var logic [tldm_pkg::CSR_W-1:0]            csr_wdata
);

   tldm_pkg::cfg_type    cfg_ff;
   tldm_pkg::item_type   item_ff;
   tldm_pkg::item_type   item_in;
   logic                 item_valid_ff;
   tldm_pkg::result_type rsp_ff;
   tldm_pkg::result_type result;
   tldm_pkg::update_type update;
   logic                 rsp_valid_ff;
   logic                 rsp_load;
   logic                 advance;

   logic signed [tldm_pkg::SAMPLE_W-1:0] prev_ff [tldm_pkg::NUM_CH];
   logic signed [tldm_pkg::SAMPLE_W-1:0] sent_ff [tldm_pkg::NUM_CH];
   logic [tldm_pkg::NUM_CH-1:0]          limit_ff;

   assign rsp_load   = !rsp_valid_ff || rsp_tready;
   assign advance    = item_valid_ff && rsp_load;
   assign req_tready = !item_valid_ff || advance;

   assign item_in.func            = req_tuser;
   assign item_in.channel         = req_tdata[1:0];
   assign item_in.temperature     = req_tdata[16:2];
   assign item_in.restart_pending = req_tdata[17];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            tldm_pkg::REG_REACTION: cfg_ff.reaction_bits  <= csr_wdata;
            tldm_pkg::REG_TH1:      cfg_ff.first_codes    <= csr_wdata[tldm_pkg::CODES_W-1:0];
            tldm_pkg::REG_TH2:      cfg_ff.second_codes   <= csr_wdata[tldm_pkg::CODES_W-1:0];
            tldm_pkg::REG_DELTA:    cfg_ff.delta_settings <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         item_ff <= item_in;
      end
   end

   tldm_eval u_eval (
      .item        (item_ff),
      .cfg         (cfg_ff),
      .prev_sample (prev_ff[item_ff.channel]),
      .last_sent   (sent_ff[item_ff.channel]),
      .limit_old   (limit_ff[item_ff.channel]),
      .result      (result),
      .update      (update)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
         for (int i = 0; i < tldm_pkg::NUM_CH; i++) begin
            prev_ff[i] <= '0;
            sent_ff[i] <= '0;
         end
      end else if (advance) begin
         limit_ff[item_ff.channel] <= update.limit_new;
         if (update.sample_we) begin
            prev_ff[item_ff.channel] <= update.sample_new;
         end
         if (update.sent_we) begin
            sent_ff[item_ff.channel] <= prev_ff[item_ff.channel];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= item_valid_ff;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.start_delta_delay, rsp_ff.send_limit,
                        rsp_ff.limit_state, rsp_ff.out_channel};

endmodule

`default_nettype wire
